>>> hw/rtl/hssq_pkg.sv
// shared types, constants and the coil pattern table for the half-step sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hssq_pkg;

  localparam int CountBits = 20;
  localparam int HoldBits  = 8;

  localparam logic [HoldBits-1:0] HoldReset = 8'd5;

  // command codes carried in tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  typedef logic [CountBits-1:0] count_t;
  typedef logic [HoldBits-1:0]  hold_t;

  typedef struct packed {
    logic       rejected;
    logic       move_done;
    logic       busy_res;
    logic [3:0] coil_pattern;
  } result_t;

  function automatic logic [3:0] coil_of(input logic [2:0] phase);
    logic [3:0] pat;
    case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/half_step_stepper_sequencer_unit.sv
// top level of the half-step stepper sequencer: stream ports, hold register, result register
// depends on hssq_pkg and hssq_core
// the result is valid in the cycle after the input transfer
// throughput: one item per cycle while out_tready is high, set by the single result register
// a new item is taken while the result waits, if out_tready is high that cycle
// reset: synchronous active-low rst_n; coils released, idle, hold register 5
`timescale 1ns / 1ps
`default_nettype none

module half_step_stepper_sequencer_unit (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [23:0] in_tdata,   // step_count[19:0], zero pad
  input  wire [0:0]  in_tuser,   // command
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // coil_pattern[3:0], busy_res, move_done, rejected, zero pad
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [7:0]  cfg_data    // step_hold_ticks
);
  import hssq_pkg::*;

  hold_t   hold_r;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    in_xfer;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= HoldReset;
    end else if (cfg_valid && cfg_ready) begin
      hold_r <= cfg_data;
    end
  end

  hssq_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_en    (in_xfer),
    .command    (in_tuser[0]),
    .step_count (in_tdata[CountBits-1:0]),
    .hold_ticks (hold_r),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

  // a stepping motor that is busy always has a coil energised
  a_busy_coil: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[3:0] != 4'h0)
    else $error("busy with coils released");

  // finishing a move releases the coils and leaves the block idle
  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[3:0] == 4'h0 && !out_tdata[4] && !out_tdata[6])
    else $error("move_done without release");

  // a rejected move leaves the block still stepping
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> out_tdata[4])
    else $error("rejected while idle");

  // the input side is open whenever no result is waiting
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

>>> hw/rtl/hssq_core.sv
// step state and half-step update, one item per transfer
// depends on hssq_pkg
`timescale 1ns / 1ps
`default_nettype none

module hssq_core (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    item_en,
  input  wire                    command,
  input  wire  hssq_pkg::count_t step_count,
  input  wire  hssq_pkg::hold_t  hold_ticks,
  output hssq_pkg::result_t      result
);
  import hssq_pkg::*;

  logic [2:0] phase_r,   phase_nxt;
  count_t     steps_r,   steps_nxt;
  hold_t      hold_r,    hold_nxt;
  logic       moving_r,  moving_nxt;
  logic       reverse_r, reverse_nxt;
  logic [3:0] coil_r,    coil_nxt;

  logic       done;
  logic       rej;
  logic       rev_in;
  count_t     mag;
  hold_t      hold_load;
  hold_t      hold_dec;
  logic       step_now;
  logic       dir_rev;
  logic [2:0] phase_step;

  assign rev_in    = step_count[CountBits-1];
  assign mag       = rev_in ? (~step_count + count_t'(1)) : step_count;
  assign hold_load = (hold_ticks == '0) ? hold_t'(1) : hold_ticks;
  assign hold_dec  = (hold_r != '0) ? (hold_r - hold_t'(1)) : hold_r;
  assign dir_rev   = (command == CMD_MOVE) ? rev_in : reverse_r;
  assign phase_step = dir_rev ? (phase_r - 3'd1) : (phase_r + 3'd1);

  always_comb begin
    phase_nxt   = phase_r;
    steps_nxt   = steps_r;
    hold_nxt    = hold_r;
    moving_nxt  = moving_r;
    reverse_nxt = reverse_r;
    coil_nxt    = coil_r;
    done        = 1'b0;
    rej         = 1'b0;
    step_now    = 1'b0;
    if (command == CMD_MOVE) begin
      if (moving_r) begin
        rej = 1'b1;
      end else if (step_count == '0) begin
        coil_nxt = 4'h0;
        done     = 1'b1;
      end else begin
        reverse_nxt = rev_in;
        steps_nxt   = mag - count_t'(1);
        moving_nxt  = 1'b1;
        step_now    = 1'b1;
      end
    end else if (moving_r) begin
      hold_nxt = hold_dec;
      if (hold_dec == '0) begin
        if (steps_r != '0) begin
          steps_nxt = steps_r - count_t'(1);
          step_now  = 1'b1;
        end else begin
          coil_nxt   = 4'h0;
          moving_nxt = 1'b0;
          done       = 1'b1;
        end
      end
    end
    if (step_now) begin
      phase_nxt = phase_step;
      coil_nxt  = coil_of(phase_step);
      hold_nxt  = hold_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      steps_r   <= '0;
      hold_r    <= '0;
      moving_r  <= 1'b0;
      reverse_r <= 1'b0;
      coil_r    <= 4'h0;
    end else if (item_en) begin
      phase_r   <= phase_nxt;
      steps_r   <= steps_nxt;
      hold_r    <= hold_nxt;
      moving_r  <= moving_nxt;
      reverse_r <= reverse_nxt;
      coil_r    <= coil_nxt;
    end
  end

  assign result.coil_pattern = coil_nxt;
  assign result.busy_res     = moving_nxt;
  assign result.move_done    = done;
  assign result.rejected     = rej;

endmodule

`default_nettype wire
